/* hw/rtl/irdl_pkg.sv */
package irdl_pkg;

    // configuration register file contents
    typedef struct packed {
        logic [11:0] breakpoint_mv;
        logic [8:0]  new_weight;
    } t_cfg;

    localparam int unsigned CFG_AW = 3;

    // register index, taken from paddr[2]
    localparam logic REG_BREAKPOINT = 1'b0;
    localparam logic REG_WEIGHT     = 1'b1;

    localparam logic [11:0] BREAKPOINT_RST = 12'd700;
    localparam logic [8:0]  WEIGHT_RST     = 9'd205;
    localparam logic [8:0]  WEIGHT_FULL    = 9'd256;

    // millivolts to volts in Q16: (mv * 65536 + 500) / 1000
    localparam logic [28:0] MV_ROUND    = 29'd500;
    localparam logic [28:0] MV_DIV      = 29'd1000;
    localparam int unsigned VQ_SHIFT    = 40;
    localparam logic [31:0] MV_RECIP    = 32'd1099511627;   // floor(2^40 / 1000)
    localparam int unsigned AVG_SHIFT   = 32;

    // curve coefficients in tenths of a cm: k2*V^2 + k1*V + k0
    localparam logic signed [10:0] UP_K2 = 11'sd22;
    localparam logic signed [10:0] UP_K1 = -11'sd180;
    localparam logic signed [10:0] UP_K0 = 11'sd413;
    localparam logic signed [10:0] LO_K2 = 11'sd116;
    localparam logic signed [10:0] LO_K1 = -11'sd546;
    localparam logic signed [10:0] LO_K0 = 11'sd732;

endpackage

/* hw/rtl/ir_distance_linearize_filter.sv */
// IR distance linearizer with block averaging and smoothing.
//
// Input channel: i_in_valid / o_in_stall carry one converter word
// (i_sample_mv, millivolts). Output channel: o_out_valid / i_out_stall
// carry one word (o_distance_cm) per BLOCK_LEN input words.
// A word moves when valid is high and stall is low at a rising edge.
//
// All arithmetic runs through one shared 32x32 multiplier under a
// sequencer, so an input word occupies the block until the sequencer
// returns to idle (o_in_stall stays high after acceptance). The last
// word of a block also runs the averaging and smoothing steps before
// its result is presented in the output register.
// The output register frees the input side: a result may wait on a
// stalled receiver while the next samples are processed; only the next
// block's result waits for it to drain.
// Reset (i_rst_n, synchronous, active low) clears the sum, count and
// smoothed value and restores the register defaults (breakpoint 700 mV,
// new weight 205/256). Registers sit on an APB port at 0x0 and 0x4.
module ir_distance_linearize_filter
    import irdl_pkg::*;
#(
    parameter int BLOCK_LEN = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [11:0]       i_sample_mv,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_distance_cm,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int          DIV_D     = BLOCK_LEN * 10;
    localparam int          CNT_W     = $clog2(BLOCK_LEN + 1);
    localparam logic [28:0] DIV_D_W   = 29'(DIV_D);
    localparam logic [31:0] AVG_RECIP = 32'((64'd1 << AVG_SHIFT) / DIV_D);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_VQ_MUL  = 4'd1;
    localparam logic [3:0] ST_VQ_EST  = 4'd2;
    localparam logic [3:0] ST_VQ_FIX  = 4'd3;
    localparam logic [3:0] ST_P_LIN   = 4'd4;
    localparam logic [3:0] ST_P_ADD   = 4'd5;
    localparam logic [3:0] ST_P_SQR   = 4'd6;
    localparam logic [3:0] ST_P_RND   = 4'd7;
    localparam logic [3:0] ST_ACC     = 4'd8;
    localparam logic [3:0] ST_AVG_MUL = 4'd9;
    localparam logic [3:0] ST_AVG_EST = 4'd10;
    localparam logic [3:0] ST_AVG_FIX = 4'd11;
    localparam logic [3:0] ST_SM_NEW  = 4'd12;
    localparam logic [3:0] ST_SM_OLD  = 4'd13;
    localparam logic [3:0] ST_SM_SUM  = 4'd14;
    localparam logic [3:0] ST_EMIT    = 4'd15;

    t_cfg cfg;

    logic [3:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [15:0]        r_sum, n_sum;
    logic [15:0]        r_smooth, n_smooth;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out, n_out;
    logic [28:0]        r_num, n_num;
    logic               r_upper, n_upper;
    logic [23:0]        r_q, n_q;
    logic [18:0]        r_vq, n_vq;
    logic signed [31:0] r_p, n_p;
    logic [15:0]        r_tenths, n_tenths;
    logic [29:0]        r_acc, n_acc;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    logic               in_accept;
    logic               last;
    logic [28:0]        div_rem;
    logic signed [10:0] coef_k2, coef_k1, coef_k0;
    logic signed [63:0] poly_u;
    logic signed [63:0] poly_rnd;
    logic [16:0]        sum_ext;
    logic [8:0]         w_new, w_old;
    logic [30:0]        sm_total;

    irdl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irdl_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign last      = (r_cnt == CNT_W'(BLOCK_LEN - 1));
    assign div_rem   = r_num - prod[28:0];

    assign coef_k2 = r_upper ? UP_K2 : LO_K2;
    assign coef_k1 = r_upper ? UP_K1 : LO_K1;
    assign coef_k0 = r_upper ? UP_K0 : LO_K0;

    assign poly_u   = prod + (64'(coef_k0) <<< 32);
    assign poly_rnd = poly_u + (64'sd1 <<< 31);
    assign sum_ext  = {1'b0, r_sum} + {1'b0, r_tenths};

    assign w_new    = (cfg.new_weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg.new_weight;
    assign w_old    = WEIGHT_FULL - w_new;
    assign sm_total = {1'b0, r_acc} + {1'b0, prod[29:0]};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_smooth    = r_smooth;
        n_out       = r_out;
        n_num       = r_num;
        n_upper     = r_upper;
        n_q         = r_q;
        n_vq        = r_vq;
        n_p         = r_p;
        n_tenths    = r_tenths;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && i_out_stall;
        mul_a       = 32'sd0;
        mul_b       = 32'sd0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_num   = {1'b0, i_sample_mv, 16'd0} + MV_ROUND;
                    n_upper = (i_sample_mv > cfg.breakpoint_mv);
                    n_state = ST_VQ_MUL;
                end
            end
            ST_VQ_MUL: begin
                mul_a   = {3'd0, r_num};
                mul_b   = MV_RECIP;
                n_state = ST_VQ_EST;
            end
            ST_VQ_EST: begin
                // reciprocal estimate is exact or one short
                n_q     = {5'd0, prod[VQ_SHIFT +: 19]};
                mul_a   = {13'd0, prod[VQ_SHIFT +: 19]};
                mul_b   = {3'd0, MV_DIV};
                n_state = ST_VQ_FIX;
            end
            ST_VQ_FIX: begin
                n_vq    = (div_rem >= MV_DIV) ? r_q[18:0] + 19'd1 : r_q[18:0];
                n_state = ST_P_LIN;
            end
            ST_P_LIN: begin
                mul_a   = 32'(coef_k2);
                mul_b   = {13'd0, r_vq};
                n_state = ST_P_ADD;
            end
            ST_P_ADD: begin
                // horner: (k2*v + k1) * v + k0
                n_p     = $signed(prod[31:0]) + (32'(coef_k1) <<< 16);
                n_state = ST_P_SQR;
            end
            ST_P_SQR: begin
                mul_a   = r_p;
                mul_b   = {13'd0, r_vq};
                n_state = ST_P_RND;
            end
            ST_P_RND: begin
                if (poly_u[63]) begin
                    n_tenths = 16'd0;
                end else if (poly_rnd[63:48] != 16'd0) begin
                    n_tenths = 16'hFFFF;
                end else begin
                    n_tenths = poly_rnd[47:32];
                end
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (last) begin
                    n_num   = {5'd0, (sum_ext[16] ? 16'hFFFF : sum_ext[15:0]), 8'd0};
                    n_sum   = 16'd0;
                    n_cnt   = '0;
                    n_state = ST_AVG_MUL;
                end else begin
                    n_sum   = sum_ext[16] ? 16'hFFFF : sum_ext[15:0];
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = ST_IDLE;
                end
            end
            ST_AVG_MUL: begin
                mul_a   = {3'd0, r_num};
                mul_b   = AVG_RECIP;
                n_state = ST_AVG_EST;
            end
            ST_AVG_EST: begin
                n_q     = prod[AVG_SHIFT +: 24];
                mul_a   = {8'd0, prod[AVG_SHIFT +: 24]};
                mul_b   = {3'd0, DIV_D_W};
                n_state = ST_AVG_FIX;
            end
            ST_AVG_FIX: begin
                n_q     = (div_rem >= DIV_D_W) ? r_q + 24'd1 : r_q;
                n_state = ST_SM_NEW;
            end
            ST_SM_NEW: begin
                mul_a   = 32'(w_new);
                mul_b   = {8'd0, r_q};
                n_state = ST_SM_OLD;
            end
            ST_SM_OLD: begin
                n_acc   = prod[29:0];
                mul_a   = 32'(w_old);
                mul_b   = {16'd0, r_smooth};
                n_state = ST_SM_SUM;
            end
            ST_SM_SUM: begin
                n_smooth = (sm_total[30:24] != 7'd0) ? 16'hFFFF : sm_total[23:8];
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                // wait here only while an earlier result is still held
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_smooth[15:8];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_sum       <= 16'd0;
            r_smooth    <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_smooth    <= n_smooth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_num    <= n_num;
        r_upper  <= n_upper;
        r_q      <= n_q;
        r_vq     <= n_vq;
        r_p      <= n_p;
        r_tenths <= n_tenths;
        r_acc    <= n_acc;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_distance_cm = r_out;

    a_vq_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VQ_FIX) |-> (div_rem < (MV_DIV + MV_DIV)))
        else $error("voltage reciprocal estimate off by more than one");

    a_avg_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AVG_FIX) |-> (div_rem < (DIV_D_W + DIV_D_W)))
        else $error("average reciprocal estimate off by more than one");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(BLOCK_LEN))
        else $error("sample count beyond block length");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result word raised outside the emit step");

endmodule

/* hw/rtl/irdl_mul.sv */
module irdl_mul
    import irdl_pkg::*;
(
    input  logic                i_clk,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output logic signed [63:0]  o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/irdl_cfg.sv */
module irdl_cfg
    import irdl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_BREAKPOINT: n_cfg.breakpoint_mv = pwdata[11:0];
                REG_WEIGHT:     n_cfg.new_weight    = pwdata[8:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.breakpoint_mv <= BREAKPOINT_RST;
            r_cfg.new_weight    <= WEIGHT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BREAKPOINT: prdata = {20'd0, r_cfg.breakpoint_mv};
            REG_WEIGHT:     prdata = {23'd0, r_cfg.new_weight};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

/* test/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irdl_pkg::*;

    localparam int BLOCK_LEN    = 10;
    localparam int RANDOM_WORDS = 1000;
    localparam int SETTLE       = 24;
    localparam int WATCHDOG     = 2000;
    localparam int DIR_N        = 20;
    localparam int SET_N        = 6;

    // curve coefficients: tenths of a cm, Q16
    localparam longint UP_A2 = 64'd22 * 65536;
    localparam longint UP_A1 = -64'sd180 * 65536;
    localparam longint UP_A0 = 64'd413 * 65536;
    localparam longint LO_A2 = 64'd116 * 65536;
    localparam longint LO_A1 = -64'sd546 * 65536;
    localparam longint LO_A0 = 64'd732 * 65536;

    typedef struct {
        logic [11:0] mv;
        bit          typed;
        logic [7:0]  cm;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [11:0]       i_sample_mv = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [7:0]        o_distance_cm;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [CFG_AW-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    ir_distance_linearize_filter #(
        .BLOCK_LEN(BLOCK_LEN)
    ) dut (.*);

    // predictor state
    logic [11:0] cfg_breakpoint = BREAKPOINT_RST;
    logic [8:0]  cfg_weight     = WEIGHT_RST;
    int unsigned blk_count      = 0;
    logic [15:0] tenths_acc     = '0;
    logic [15:0] smooth_q8      = '0;

    logic [7:0] distance_q[$];
    logic [7:0] want_cm;
    int         fail_count   = 0;
    int         words_sent   = 0;
    int         results_seen = 0;
    int         settings     = 0;
    int         idle_cycles  = 0;
    int         stall_left   = 0;
    bit         tx_quiet     = 1'b0;
    bit         rx_quiet     = 1'b0;

    // reset state, then extremes, breakpoint edges and alternating bit patterns
    t_dir_row dir_rows [DIR_N] = '{
        '{12'd0, 1'b0, 8'd0}, '{12'd0, 1'b0, 8'd0}, '{12'd0, 1'b0, 8'd0},
        '{12'd0, 1'b0, 8'd0}, '{12'd0, 1'b0, 8'd0}, '{12'd0, 1'b0, 8'd0},
        '{12'd0, 1'b0, 8'd0}, '{12'd0, 1'b0, 8'd0}, '{12'd0, 1'b0, 8'd0},
        '{12'd0, 1'b1, 8'd58},
        '{12'd4095, 1'b0, 8'd0}, '{12'd700, 1'b0, 8'd0}, '{12'd701, 1'b0, 8'd0},
        '{12'd1, 1'b0, 8'd0}, '{12'd4094, 1'b0, 8'd0}, '{12'd2048, 1'b0, 8'd0},
        '{12'hAAA, 1'b0, 8'd0}, '{12'h555, 1'b0, 8'd0}, '{12'd699, 1'b0, 8'd0},
        '{12'd4095, 1'b0, 8'd0}
    };

    logic [11:0] bp_set [SET_N] = '{12'd700, 12'd0, 12'd4095, 12'd1234, 12'd2048, 12'd350};
    logic [8:0]  wt_set [SET_N] = '{9'd205, 9'd256, 9'd0, 9'd511, 9'd300, 9'd1};

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] tenths_of(input logic [11:0] mv);
        longint vq, a2, a1, a0, t;
        longint unsigned r;
        vq = (longint'(mv) * 65536 + 500) / 1000;
        if (mv > cfg_breakpoint) begin
            a2 = UP_A2; a1 = UP_A1; a0 = UP_A0;
        end else begin
            a2 = LO_A2; a1 = LO_A1; a0 = LO_A0;
        end
        t = a2 * vq * vq + a1 * vq * 65536 + a0 * (longint'(1) << 32);
        if (t < 0)
            return 16'd0;
        r = (64'(t) + (64'd1 << 47)) >> 48;
        if (r > 64'd65535)
            r = 64'd65535;
        return r[15:0];
    endfunction

    // accumulate one word; returns 1 when the block closes with a distance
    function automatic bit take_word(input logic [11:0] mv, output logic [7:0] cm);
        logic [16:0]     s;
        longint unsigned w, avg, sm;
        cm = '0;
        s  = tenths_acc + tenths_of(mv);
        if (s > 17'd65535)
            s = 17'd65535;
        if (blk_count + 1 < BLOCK_LEN) begin
            tenths_acc = s[15:0];
            blk_count++;
            return 1'b0;
        end
        w   = (cfg_weight > WEIGHT_FULL) ? 64'd256 : 64'(cfg_weight);
        avg = (64'(s) * 256) / (BLOCK_LEN * 10);
        sm  = (w * avg + (64'd256 - w) * 64'(smooth_q8)) >> 8;
        if (sm > 64'd65535)
            sm = 64'd65535;
        smooth_q8  = sm[15:0];
        tenths_acc = '0;
        blk_count  = 0;
        cm = smooth_q8[15:8];
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int stall_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    endfunction

    function automatic logic [11:0] pick_mv();
        int r, v;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 12'($urandom_range(0, 4095));
        if (r < 88) begin
            v = int'(cfg_breakpoint) + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            return 12'(v);
        end
        case ($urandom_range(0, 3))
            0: return 12'd0;
            1: return 12'd1;
            2: return 12'd4094;
            default: return 12'd4095;
        endcase
    endfunction

    task automatic send_word(input logic [11:0] mv, input bit typed, input logic [7:0] typed_cm);
        int          gap;
        logic [7:0]  cm;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_mv <= mv;
        do @(posedge i_clk); while (o_in_stall);
        if (take_word(mv, cm))
            distance_q.push_back(typed ? typed_cm : cm);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_BREAKPOINT)
            cfg_breakpoint = value[11:0];
        else
            cfg_weight = value[8:0];
        @(posedge i_clk);
    endtask

    task automatic apb_check(input logic idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata != want) begin
            $error("%s readback: expected %0d, got %0d",
                   (idx == REG_BREAKPOINT) ? "breakpoint_mv" : "new_weight", want, prdata);
            fail_count++;
        end
        @(posedge i_clk);
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_quiet || $urandom_range(0, 3) != 0) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_left  <= stall_len() - 1;
            i_out_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (distance_q.size() == 0) begin
                $error("distance_cm: no word expected, got %0d", o_distance_cm);
                fail_count++;
            end else begin
                want_cm = distance_q.pop_front();
                if (o_distance_cm !== want_cm) begin
                    $error("distance_cm: expected %0d, got %0d", want_cm, o_distance_cm);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          random_sent;
        int          n;
        logic [11:0] bp;
        logic [8:0]  wt;
        random_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].mv, dir_rows[k].typed, dir_rows[k].cm);

        while (random_sent < RANDOM_WORDS) begin
            // registers only move with the pipeline empty
            drain();
            if (settings < SET_N) begin
                bp = bp_set[settings];
                wt = wt_set[settings];
            end else begin
                bp = 12'($urandom_range(0, 4095));
                wt = 9'($urandom_range(0, 511));
            end
            apb_write(REG_BREAKPOINT, 32'(bp));
            apb_write(REG_WEIGHT, 32'(wt));
            apb_check(REG_BREAKPOINT, 32'(bp));
            apb_check(REG_WEIGHT, 32'(wt));
            settings++;
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= ($urandom_range(0, 3) == 0);
            n = $urandom_range(90, 160);
            repeat (n) send_word(pick_mv(), 1'b0, 8'd0);
            random_sent += n;
        end

        drain();
        $display("%0d sensor words over %0d register settings, %0d distances checked",
                 words_sent, settings, results_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
